// File: rtl/core/zrle_pkg.sv
// shared types and constants of the zero-run / literal run-length encoder
`default_nettype none

package zrle_pkg;

   localparam int LIT_DEPTH = 61;
   localparam int MAX_ZERO_RUN = 32767;
   localparam int LEN_W = 15;
   localparam int LIT_IDX_W = $clog2(LIT_DEPTH);
   localparam int CNT_W = $clog2(LIT_DEPTH + 1);

   typedef enum logic [1:0] {
      RUN_NONE = 2'd0,
      RUN_ZERO = 2'd1,
      RUN_LIT  = 2'd2
   } run_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HDR  = 4'b0010,
      ST_DATA = 4'b0100,
      ST_PEND = 4'b1000
   } state_type;

   localparam logic ITEM_HEADER = 1'b0;
   localparam logic ITEM_DATA   = 1'b1;

   typedef struct packed {
      logic                 write_en;
      logic                 shift_en;
      logic [LIT_IDX_W-1:0] write_idx;
      logic [7:0]           write_byte;
   } lit_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/zrle_cell.sv
// one byte cell of the literal chain
`default_nettype none

module zrle_cell (
   input  wire logic       clock,
   input  wire logic       shift_en,
   input  wire logic       write_hit,
   input  wire logic [7:0] write_byte,
   input  wire logic [7:0] nbr_byte,
   output logic [7:0]      byte_ff
);

   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (shift_en) begin
         byte_in = nbr_byte;
      end else if (write_hit) begin
         byte_in = write_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/zrle_lit_chain.sv
// row of byte cells holding the open literal run, drained from cell 0
`default_nettype none

module zrle_lit_chain (
   input  wire logic                  clock,
   input  wire zrle_pkg::lit_ctrl_type ctrl,
   output logic [7:0]                 head_byte
);

   logic [7:0] cell_byte [zrle_pkg::LIT_DEPTH];
   logic [7:0] nbr_byte  [zrle_pkg::LIT_DEPTH];

   for (genvar i = 0; i < zrle_pkg::LIT_DEPTH; i++) begin : g_cell
      logic hit;

      assign hit = ctrl.write_en &&
                   (ctrl.write_idx == zrle_pkg::LIT_IDX_W'(i));

      if (i == zrle_pkg::LIT_DEPTH - 1) begin : g_tail
         assign nbr_byte[i] = 8'd0;
      end else begin : g_mid
         assign nbr_byte[i] = cell_byte[i+1];
      end

      zrle_cell u_cell (
         .clock      (clock),
         .shift_en   (ctrl.shift_en),
         .write_hit  (hit),
         .write_byte (ctrl.write_byte),
         .nbr_byte   (nbr_byte[i]),
         .byte_ff    (cell_byte[i])
      );
   end

   assign head_byte = cell_byte[0];

endmodule

`default_nettype wire

// File: rtl/core/zero_run_literal_rle_encoder_top.sv
// top level of the zero-run / literal-packet run-length encoder
//
// input channel req_*: one raw byte per transfer, req_end_of_input marks the
// last byte of a stream; the open run is flushed right after that byte.
// result channel rsp_*: header words (item_kind 0) and literal bytes
// (item_kind 1); rsp_last_of_burst flags the final result caused by one input.
// a byte that only extends or opens a run is taken without a stall, so such
// bytes stream at one per cycle with no result.
// a byte that closes a run is parked and holds the input off while the run
// drains through the output register: the header first, then each literal
// byte (at most 61), and last the held byte is filed as a new run.
// literal bytes sit in a row of 61 cells and leave through cell 0, one shift
// per literal result transfer; that drain sets the worst-case input rate.
// between the deciding transfer and its first result lie the state register and the output register.
// reset (synchronous) drops any open run and any pending result.
// while rsp_stall is high the output register holds its item and the drain
// simply waits; no result is lost or repeated.
`default_nettype none

module zero_run_literal_rle_encoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_item_kind,
   output logic [15:0]      rsp_item_value,
   output logic             rsp_last_of_burst
);

   localparam int LEN_W = zrle_pkg::LEN_W;
   localparam int CNT_W = zrle_pkg::CNT_W;

   // control state
   zrle_pkg::state_type    state_ff, state_in;
   zrle_pkg::run_kind_type kind_ff, kind_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // held byte that closed the previous run
   logic [7:0]             pend_byte_ff, pend_byte_in;
   logic                   pend_eoi_ff, pend_eoi_in;

   // output register payload
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [15:0]            rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;

   zrle_pkg::lit_ctrl_type lit_ctrl;
   logic [7:0]             head_byte;

   logic                   out_free;
   logic                   req_lit;
   logic                   at_limit;
   logic                   close_old;
   logic [7:0]             ap_byte;
   logic                   ap_eoi;
   logic                   ap_lit;
   logic                   more_after;
   logic [CNT_W-1:0]       lit_count;

   zrle_lit_chain u_chain (
      .clock     (clock),
      .ctrl      (lit_ctrl),
      .head_byte (head_byte)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != zrle_pkg::ST_IDLE);

   // does the arriving byte close the open run
   assign req_lit  = (req_data_byte != 8'd0);
   assign at_limit = req_lit ? (len_ff >= LEN_W'(zrle_pkg::LIT_DEPTH))
                             : (len_ff >= LEN_W'(zrle_pkg::MAX_ZERO_RUN));
   assign close_old = (kind_ff != zrle_pkg::RUN_NONE) &&
                      (((kind_ff == zrle_pkg::RUN_LIT) != req_lit) || at_limit);

   // byte being filed into the run: held one after a drain, else the live one
   assign ap_byte = (state_ff == zrle_pkg::ST_PEND) ? pend_byte_ff : req_data_byte;
   assign ap_eoi  = (state_ff == zrle_pkg::ST_PEND) ? pend_eoi_ff : req_end_of_input;
   assign ap_lit  = (ap_byte != 8'd0);

   // a held end-of-input byte still produces results after this run
   assign more_after = pend_ff && pend_eoi_ff;

   assign lit_count = (len_ff >= LEN_W'(zrle_pkg::LIT_DEPTH)) ?
                      CNT_W'(zrle_pkg::LIT_DEPTH) : CNT_W'(len_ff);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_byte_in = pend_byte_ff;
      pend_eoi_in  = pend_eoi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      lit_ctrl     = '0;

      case (state_ff)
         zrle_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (close_old) begin
                  // park the byte until the old run has drained
                  pend_in      = 1'b1;
                  pend_byte_in = req_data_byte;
                  pend_eoi_in  = req_end_of_input;
                  state_in     = zrle_pkg::ST_HDR;
               end else begin
                  lit_ctrl.write_en   = ap_lit && (len_ff < LEN_W'(zrle_pkg::LIT_DEPTH));
                  lit_ctrl.write_idx  = len_ff[zrle_pkg::LIT_IDX_W-1:0];
                  lit_ctrl.write_byte = ap_byte;
                  kind_in = ap_lit ? zrle_pkg::RUN_LIT : zrle_pkg::RUN_ZERO;
                  len_in  = len_ff + LEN_W'(1);
                  if (ap_eoi) begin
                     pend_in  = 1'b0;
                     state_in = zrle_pkg::ST_HDR;
                  end
               end
            end
         end

         zrle_pkg::ST_HDR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = zrle_pkg::ITEM_HEADER;
               rsp_value_in = {(kind_ff == zrle_pkg::RUN_ZERO), len_ff};
               kind_in      = zrle_pkg::RUN_NONE;
               len_in       = '0;
               cnt_in       = lit_count;
               if (kind_ff == zrle_pkg::RUN_LIT) begin
                  rsp_last_in = 1'b0;
                  state_in    = zrle_pkg::ST_DATA;
               end else begin
                  rsp_last_in = !more_after;
                  state_in    = pend_ff ? zrle_pkg::ST_PEND : zrle_pkg::ST_IDLE;
               end
            end
         end

         zrle_pkg::ST_DATA: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = zrle_pkg::ITEM_DATA;
               rsp_value_in      = {8'd0, head_byte};
               rsp_last_in       = (cnt_ff == CNT_W'(1)) && !more_after;
               lit_ctrl.shift_en = 1'b1;
               cnt_in            = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = pend_ff ? zrle_pkg::ST_PEND : zrle_pkg::ST_IDLE;
               end
            end
         end

         zrle_pkg::ST_PEND: begin
            // run registers were cleared by the header, so this opens a fresh run
            pend_in             = 1'b0;
            lit_ctrl.write_en   = ap_lit && (len_ff < LEN_W'(zrle_pkg::LIT_DEPTH));
            lit_ctrl.write_idx  = len_ff[zrle_pkg::LIT_IDX_W-1:0];
            lit_ctrl.write_byte = ap_byte;
            kind_in  = ap_lit ? zrle_pkg::RUN_LIT : zrle_pkg::RUN_ZERO;
            len_in   = len_ff + LEN_W'(1);
            state_in = ap_eoi ? zrle_pkg::ST_HDR : zrle_pkg::ST_IDLE;
         end

         default: begin
            state_in = zrle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zrle_pkg::ST_IDLE;
         kind_ff      <= zrle_pkg::RUN_NONE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      pend_eoi_ff  <= pend_eoi_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_item_kind     = rsp_kind_ff;
   assign rsp_item_value    = rsp_value_ff;
   assign rsp_last_of_burst = rsp_last_ff;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for the zero-run / literal-packet run-length encoder
`timescale 1ns / 1ps

module testbench;

   // one raw byte as offered on the input channel
   typedef struct packed {
      logic [7:0] data;
      logic       eoi;
   } raw_byte_type;

   // one encoded item as it should leave the result channel
   typedef struct packed {
      logic        kind;
      logic [15:0] value;
      logic        burst_end;
   } coded_item_type;

   localparam int IDLE_PCT = 27;
   // longest stretch with no transfer on either side before giving up;
   // it must outlast the forced output hold-off, random stalls are short
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_ITEMS = 260;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_kind;
   logic [15:0] rsp_item_value;
   logic        rsp_last_of_burst;

   raw_byte_type   raw_bytes[$];
   coded_item_type encoded_items[$];

   // predictor state: the open run and the literal bytes collected so far
   zrle_pkg::run_kind_type     open_kind = zrle_pkg::RUN_NONE;
   logic [zrle_pkg::LEN_W-1:0] open_len = '0;
   logic [7:0]                 lit_copy [zrle_pkg::LIT_DEPTH];

   int errors = 0;
   int queued_bytes = 0;
   int bytes_in = 0;
   int streams_done = 0;
   int results_seen = 0;
   int headers_seen = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   zero_run_literal_rle_encoder_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_input  (req_end_of_input),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_item_value    (rsp_item_value),
      .rsp_last_of_burst (rsp_last_of_burst)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   function void push_coded(logic kind, logic [15:0] value);
      encoded_items.push_back('{kind: kind, value: value, burst_end: 1'b0});
   endfunction

   // emit the open run: zero runs as a flagged header, literal runs as a
   // plain header followed by their bytes in arrival order
   function void flush_run();
      if (open_kind == zrle_pkg::RUN_ZERO) begin
         push_coded(zrle_pkg::ITEM_HEADER, {1'b1, open_len});
      end else if (open_kind == zrle_pkg::RUN_LIT) begin
         push_coded(zrle_pkg::ITEM_HEADER, {1'b0, open_len});
         for (int i = 0; i < int'(open_len) && i < zrle_pkg::LIT_DEPTH; i++)
            push_coded(zrle_pkg::ITEM_DATA, {8'h00, lit_copy[i]});
      end
      open_kind = zrle_pkg::RUN_NONE;
      open_len = '0;
   endfunction

   // work out every item that one accepted byte causes
   function void encode_byte(logic [7:0] b, logic eoi);
      int                     before_cnt;
      zrle_pkg::run_kind_type cls;
      int                     limit;
      before_cnt = encoded_items.size();
      cls = (b == 8'h00) ? zrle_pkg::RUN_ZERO : zrle_pkg::RUN_LIT;
      limit = (cls == zrle_pkg::RUN_ZERO) ? zrle_pkg::MAX_ZERO_RUN : zrle_pkg::LIT_DEPTH;
      // class change, or a byte arriving while the run sits at its limit
      if (open_kind != zrle_pkg::RUN_NONE && (open_kind != cls || int'(open_len) >= limit))
         flush_run();
      if (cls == zrle_pkg::RUN_LIT && int'(open_len) < zrle_pkg::LIT_DEPTH)
         lit_copy[open_len] = b;
      open_kind = cls;
      open_len = open_len + 1'b1;
      if (eoi)
         flush_run();
      if (encoded_items.size() > before_cnt)
         encoded_items[encoded_items.size() - 1].burst_end = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // input driver: offers queued bytes, idles at random
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      raw_byte_type xfer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // transfer taken at this edge: predict its results
         if (req_valid && !req_stall) begin
            encode_byte(req_data_byte, req_end_of_input);
            bytes_in++;
            if (req_end_of_input)
               streams_done++;
         end
         // payload only moves once the current one is gone
         if (!req_valid || !req_stall) begin
            if (raw_bytes.size() > 0 &&
                ((bytes_in >= 150 && bytes_in < 260) || $urandom_range(99) >= IDLE_PCT)) begin
               xfer = raw_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= xfer.data;
               req_end_of_input <= xfer.eoi;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result monitor: compares each transfer with the oldest prediction
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      coded_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_item_kind == zrle_pkg::ITEM_HEADER)
               headers_seen++;
            if (encoded_items.size() == 0) begin
               $error("unexpected result: item_kind %0d item_value 0x%04h last_of_burst %0d",
                      rsp_item_kind, rsp_item_value, rsp_last_of_burst);
               errors++;
            end else begin
               want = encoded_items.pop_front();
               if (rsp_item_kind !== want.kind) begin
                  $error("item_kind: expected %0d, got %0d", want.kind, rsp_item_kind);
                  errors++;
               end
               if (rsp_item_value !== want.value) begin
                  $error("item_value: expected 0x%04h, got 0x%04h", want.value, rsp_item_value);
                  errors++;
               end
               if (rsp_last_of_burst !== want.burst_end) begin
                  $error("last_of_burst: expected %0d, got %0d", want.burst_end,
                         rsp_last_of_burst);
                  errors++;
               end
            end
            // one long hold-off early on, so the encoder backs up into its input
            if (results_seen == 40 && !hold_done) begin
               hold_done = 1'b1;
               hold_left = HOLD_OFF_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !(results_seen >= 250 && results_seen < 500) &&
                         ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: no transfer on either side for too long ends the run
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles, %0d results still awaited",
                  quiet_cycles, encoded_items.size());
         $display("zero_run_literal_rle_encoder_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   task automatic add_byte(logic [7:0] b, logic eoi);
      raw_bytes.push_back('{data: b, eoi: eoi});
      queued_bytes++;
   endtask

   // a run of one class with random nonzero content for literal runs;
   // eoi optionally marks its final byte
   task automatic add_run(zrle_pkg::run_kind_type kind, int len, logic eoi);
      for (int i = 0; i < len; i++)
         add_byte((kind == zrle_pkg::RUN_ZERO) ? 8'h00 : 8'($urandom_range(1, 255)),
                  eoi && (i == len - 1));
   endtask

   initial begin
      int                     n_runs;
      int                     len;
      int                     sel;
      int                     target;
      bit                     start_zero;
      bit                     terminate;
      zrle_pkg::run_kind_type kind;

      // directed: single-byte streams of each class, the all-ones byte
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      // literal closed by zeros, zeros closed by a literal, flush at the end
      add_byte(8'h01, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hAA, 1'b1);
      // literal closed by a zero that itself ends the stream
      add_byte(8'h55, 1'b0);
      add_byte(8'h00, 1'b1);
      // zero run closed by the final literal
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h12, 1'b1);
      // three runs in a row, each a single byte
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b1);

      // literal run at its limit twice over: 61, 61 and a one-byte tail
      add_run(zrle_pkg::RUN_LIT, 123, 1'b1);

      // random: mostly well-formed streams of alternating runs, some noise
      target = queued_bytes + RANDOM_ITEMS;
      while (queued_bytes < target) begin
         if ($urandom_range(99) < 80) begin
            n_runs = $urandom_range(1, 6);
            start_zero = $urandom_range(1);
            terminate = ($urandom_range(9) != 0);
            for (int r = 0; r < n_runs; r++) begin
               kind = ((r % 2 == 0) == start_zero) ? zrle_pkg::RUN_ZERO : zrle_pkg::RUN_LIT;
               sel = $urandom_range(99);
               if (sel < 70)
                  len = $urandom_range(1, 8);
               else if (sel < 88)
                  len = $urandom_range(9, 40);
               else
                  len = $urandom_range(58, 64);   // around the literal limit
               add_run(kind, len, terminate && (r == n_runs - 1));
            end
         end else begin
            n_runs = $urandom_range(1, 4);
            for (int i = 0; i < n_runs; i++)
               add_byte(8'($urandom_range(0, 255)), $urandom_range(3) == 0);
         end
      end

      // short closing stream so every open run is flushed
      add_run(zrle_pkg::RUN_LIT, 3, 1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (raw_bytes.size() != 0 || req_valid)
         @(posedge clock);
      while (encoded_items.size() != 0)
         @(posedge clock);
      // a late stray result would show up within one burst length
      repeat (100) @(posedge clock);

      if (encoded_items.size() != 0) begin
         $error("%0d expected results never arrived", encoded_items.size());
         errors++;
      end
      $display("covered %0d input bytes in %0d streams, %0d results (%0d headers)",
               bytes_in, streams_done, results_seen, headers_seen);
      $display("runs across the literal length limit, idle gaps and a %0d-cycle output hold-off",
               HOLD_OFF_CYCLES);
      if (errors == 0) begin
         $display("zero_run_literal_rle_encoder_top regression: pass");
      end else begin
         $display("zero_run_literal_rle_encoder_top regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/zrle_pkg.sv
rtl/core/zrle_cell.sv
rtl/core/zrle_lit_chain.sv
rtl/core/zero_run_literal_rle_encoder_top.sv
bench/testbench.sv
